// ===== hdl/ntwa_pkg.sv =====
package ntwa_pkg;

	localparam int ID_W     = 8;
	localparam int DIST_W   = 8;
	localparam int TIME_W   = 32;
	localparam int AGE_W    = 16;
	localparam int PERIOD_W = 16;
	localparam int THR_W    = 8;
	localparam int NCOUNT_W = 5;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AGE_LIMIT       = 2'd0,
		CFG_DECISION_PERIOD = 2'd1,
		CFG_CLOSE_THRESHOLD = 2'd2,
		CFG_UNUSED          = 2'd3
	} cfg_idx_t;

	localparam logic [AGE_W-1:0]    AGE_LIMIT_RST = 16'd64;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd32;
	localparam logic [THR_W-1:0]    THRESH_RST    = 8'd60;

	// One table entry as it sits in the memory.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
		logic [DIST_W-1:0] distance;
	} entry_t;

	localparam int ENTRY_W = ID_W + TIME_W + DIST_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_AGE_RD,
		ST_AGE_EV,
		ST_RESULT
	} state_t;

endpackage

// ===== hdl/ntwa_pass_if.sv =====
interface ntwa_pass_if;
	logic                          valid;
	logic                          ready;
	logic                          has_message;
	logic [ntwa_pkg::ID_W-1:0]     sender_id;
	logic [ntwa_pkg::DIST_W-1:0]   sender_distance;
	logic [ntwa_pkg::TIME_W-1:0]   now_ticks;

	modport source (
		output valid, has_message, sender_id, sender_distance, now_ticks,
		input  ready
	);

	modport sink (
		input  valid, has_message, sender_id, sender_distance, now_ticks,
		output ready
	);
endinterface

// ===== hdl/ntwa_result_if.sv =====
interface ntwa_result_if;
	logic                            valid;
	logic                            ready;
	logic                            decision_due;
	logic                            too_close;
	logic                            no_neighbors;
	logic [ntwa_pkg::NCOUNT_W-1:0]   neighbor_count;

	modport source (
		output valid, decision_due, too_close, no_neighbors, neighbor_count,
		input  ready
	);

	modport sink (
		input  valid, decision_due, too_close, no_neighbors, neighbor_count,
		output ready
	);
endinterface

// ===== hdl/neighbor_table_with_aging.sv =====
// Neighbor table with aging. Each word on the pass channel is one control-loop
// pass: the current tick and, if has_message is set, a sender id and distance.
// The sender is looked up in a table of up to MAX_NEIGHBORS entries held in a
// single RAM; a hit refreshes its timestamp and distance, a miss appends it
// (a new sender is dropped while the table is full). The table is then aged
// from the last entry down: an entry whose age exceeds age_limit is replaced
// by the last entry and the count shrinks. One result word follows per pass;
// when the decision period has elapsed it reports whether a surviving
// neighbor is closer than close_threshold and whether the table is empty.
// The lookup streams one RAM read per cycle; aging takes a read step and an
// evaluate step per entry because each entry's step reads the entry and the
// current last entry and may write back before the next read. A finished
// result sits in an output register, so the next pass is accepted while it
// waits to be taken. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while no pass is in flight, which
// the block itself does not enforce.
module neighbor_table_with_aging #(
	parameter int MAX_NEIGHBORS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ntwa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ntwa_pkg::CFG_DATA_W-1:0] cfg_data,
	ntwa_pass_if.sink                       pass,
	ntwa_result_if.source                   result
);

	import ntwa_pkg::*;

	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

	// Control state.
	state_t               state_q, state_d;
	logic [CW-1:0]        count_q;
	logic [TIME_W-1:0]    last_dec_q;
	logic [AGE_W-1:0]     age_limit_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [THR_W-1:0]     thresh_q;
	logic [CW-1:0]        rd_idx_q;
	logic                 cmp_v_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic [CW-1:0]        age_k_q;
	logic                 close_q;
	logic                 res_v_q;

	// Captured pass word.
	logic                 msg_q;
	logic [ID_W-1:0]      id_q;
	logic [DIST_W-1:0]    dist_q;
	logic [TIME_W-1:0]    now_q;

	// Result register.
	logic                 res_due_q;
	logic                 res_close_q;
	logic                 res_empty_q;
	logic [NCOUNT_W-1:0]  res_count_q;

	// RAM connections.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	logic [AW-1:0]        ram_raddr_a;
	logic [AW-1:0]        ram_raddr_b;
	logic [ENTRY_W-1:0]   ram_rdata_a;
	logic [ENTRY_W-1:0]   ram_rdata_b;
	entry_t               ent_a;
	entry_t               ent_b;

	// Datapath decisions.
	logic                 accept;
	logic                 issue;
	logic                 hit;
	logic                 miss_done;
	logic                 has_room;
	logic [CW-1:0]        count_after_msg;
	logic [CW-1:0]        last_idx;
	logic [CW-1:0]        age_prev;
	logic                 aged;
	logic                 res_load;
	logic                 due;
	logic [TIME_W-1:0]    deadline;
	logic [CW+NCOUNT_W-1:0] count_ext;

	ntwa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_NEIGHBORS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	assign ent_a = entry_t'(ram_rdata_a);
	assign ent_b = entry_t'(ram_rdata_b);

	// Lookup results. Reads are issued in index order, so the first match seen
	// is the lowest matching slot.
	assign hit       = cmp_v_s1 && (ent_a.id == id_q);
	assign miss_done = !cmp_v_s1 && (rd_idx_q == count_q);
	assign has_room  = count_q < CW'(MAX_NEIGHBORS);
	assign issue     = (state_q == ST_SEARCH) && !hit && (rd_idx_q < count_q);

	assign count_after_msg = (!hit && miss_done && has_room) ? count_q + CW'(1) : count_q;

	// Aging compares the modular age of the entry against the limit.
	assign last_idx = count_q - CW'(1);
	assign age_prev = age_k_q - CW'(1);
	assign aged     = (now_q - ent_a.stamp) > {{(TIME_W-AGE_W){1'b0}}, age_limit_q};

	assign deadline = last_dec_q + {{(TIME_W-PERIOD_W){1'b0}}, period_q};
	assign due      = now_q > deadline;

	assign accept   = pass.valid && pass.ready;
	assign res_load = (state_q == ST_RESULT) && (!res_v_q || result.ready);

	assign count_ext = {{NCOUNT_W{1'b0}}, count_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pass.valid) begin
					state_d = pass.has_message ? ST_SEARCH : ST_AGE_RD;
				end
			end
			ST_SEARCH: begin
				if (hit || miss_done) begin
					state_d = ST_AGE_RD;
				end
			end
			ST_AGE_RD: begin
				state_d = (age_k_q == '0) ? ST_RESULT : ST_AGE_EV;
			end
			ST_AGE_EV: begin
				state_d = ST_AGE_RD;
			end
			ST_RESULT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake and RAM controls.
	always_comb begin
		pass.ready  = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = cmp_idx_s1;
		ram_raddr_a = rd_idx_q[AW-1:0];
		ram_raddr_b = last_idx[AW-1:0];
		ram_wdata   = '{id: id_q, stamp: now_q, distance: dist_q};
		unique case (state_q)
			ST_IDLE: begin
				pass.ready = 1'b1;
			end
			ST_SEARCH: begin
				// A hit refreshes its slot; a miss appends when there is room.
				ram_we    = hit || (miss_done && has_room);
				ram_waddr = hit ? cmp_idx_s1 : count_q[AW-1:0];
			end
			ST_AGE_RD: begin
				ram_raddr_a = age_prev[AW-1:0];
			end
			ST_AGE_EV: begin
				// The stale entry is overwritten by the last one unless it is
				// itself the last entry, in which case only the count drops.
				ram_we    = aged && (age_k_q != last_idx);
				ram_waddr = age_k_q[AW-1:0];
				ram_wdata = ent_b;
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= AGE_LIMIT_RST;
			period_q    <= PERIOD_RST;
			thresh_q    <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AGE_LIMIT:       age_limit_q <= cfg_data[AGE_W-1:0];
				CFG_DECISION_PERIOD: period_q    <= cfg_data[PERIOD_W-1:0];
				CFG_CLOSE_THRESHOLD: thresh_q    <= cfg_data[THR_W-1:0];
				CFG_UNUSED: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer and table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			last_dec_q <= '0;
			rd_idx_q   <= '0;
			cmp_v_s1   <= 1'b0;
			age_k_q    <= '0;
			close_q    <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				rd_idx_q <= '0;
				cmp_v_s1 <= 1'b0;
				close_q  <= 1'b0;
				age_k_q  <= count_q;
			end

			if (state_q == ST_SEARCH) begin
				cmp_v_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (hit || miss_done) begin
					count_q <= count_after_msg;
					age_k_q <= count_after_msg;
				end
			end

			if (state_q == ST_AGE_RD && age_k_q != '0) begin
				age_k_q <= age_k_q - CW'(1);
			end

			if (state_q == ST_AGE_EV) begin
				if (aged) begin
					count_q <= last_idx;
				end else if (ent_a.distance < thresh_q) begin
					close_q <= 1'b1;
				end
			end

			if (res_load) begin
				res_v_q <= 1'b1;
				if (due) begin
					last_dec_q <= now_q;
				end
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			msg_q  <= pass.has_message;
			id_q   <= pass.sender_id;
			dist_q <= pass.sender_distance;
			now_q  <= pass.now_ticks;
		end
		if (state_q == ST_SEARCH) begin
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (res_load) begin
			res_due_q   <= due;
			res_close_q <= due && close_q;
			res_empty_q <= due && (count_q == '0);
			res_count_q <= count_ext[NCOUNT_W-1:0];
		end
	end

	assign result.valid          = res_v_q;
	assign result.decision_due   = res_due_q;
	assign result.too_close      = res_close_q;
	assign result.no_neighbors   = res_empty_q;
	assign result.neighbor_count = res_count_q;

	// The live count never grows past the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NEIGHBORS))
		else $error("neighbor count exceeds table size");

	// The entry under evaluation is always a live slot.
	a_age_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AGE_EV) |-> (age_k_q < count_q))
		else $error("aging step outside live entries");

	// The lookup state is only entered for a pass that carries a message.
	a_msg_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> msg_q)
		else $error("lookup without a message");

	// A new result word only appears after the result step.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> ($past(state_q) == ST_RESULT))
		else $error("result produced outside result step");

endmodule

// ===== hdl/ntwa_ram.sv =====
// Simple dual-port RAM: one write port, two registered read ports.
module ntwa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
